### rtl/button_hold_edge_toggle_tracker_core_macros.svh
// Assertion macros for the button tracker checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BUTTON_HOLD_EDGE_TOGGLE_TRACKER_CORE_MACROS_SVH
`define BUTTON_HOLD_EDGE_TOGGLE_TRACKER_CORE_MACROS_SVH

// Same-cycle implication.
`define BHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define BHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### rtl/bht_pkg.sv
// Shared types, constants and helper functions for the button tracker.
// No dependencies; used by the tracker core.
`timescale 1ns / 1ps

package bht_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int NUM_KEYS    = 14;
    localparam int COUNT_WIDTH = 16;

    // Widths of the port fields.
    localparam int PAD_W      = 16;
    localparam int KEY_W      = 14;
    localparam int BUTTON_W   = 5;
    localparam int VALUE_W    = 16;
    localparam int MAP_FIELD_W = 4;
    localparam int KEY_MAP_W  = KEY_W * MAP_FIELD_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = KEY_MAP_W;

    // Index of one button inside the counter bank.
    localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // The key max tree always works on sixteen slots.
    localparam int KEY_SLOTS = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef count_t [KEY_SLOTS-1:0] key_slots_t;

    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Request kinds.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Query modes.
    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_TRIGGER = 2'd1,
        MODE_TOGGLE  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MAP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ENABLE = 2'd1;

    // Saturating hold counter: counts while pressed, clears on release.
    function automatic count_t bump(input count_t c, input logic pressed);
        count_t r;
        if (!pressed)
            r = '0;
        else if (c != COUNT_MAX)
            r = c + count_t'(1);
        else
            r = COUNT_MAX;
        return r;
    endfunction

    function automatic count_t max2(input count_t a, input count_t b);
        return (a > b) ? a : b;
    endfunction

    // Balanced four-level maximum over the sixteen key slots.
    function automatic count_t max_tree(input key_slots_t s);
        count_t l1 [8];
        count_t l2 [4];
        count_t l3 [2];
        for (int i = 0; i < 8; i++)
            l1[i] = max2(s[2*i], s[2*i+1]);
        for (int i = 0; i < 4; i++)
            l2[i] = max2(l1[2*i], l1[2*i+1]);
        for (int i = 0; i < 2; i++)
            l3[i] = max2(l2[2*i], l2[2*i+1]);
        return max2(l3[0], l3[1]);
    endfunction

    // Clamp a count to the width of the answer field.
    function automatic logic [VALUE_W-1:0] clamp_value(input count_t c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000_FFFF) ? {VALUE_W{1'b1}} : w[VALUE_W-1:0];
    endfunction

endpackage

### rtl/button_hold_edge_toggle_tracker_core.sv
// Button hold, release-edge and toggle tracker, top level.
// Depends on bht_pkg for types, codes and counter helpers.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid/in_ready) carries one beat per item: a tick
//   (req_type 0) with new pad and key samples, or a query (req_type 1) of
//   one button in one mode. Every beat yields exactly one result beat on
//   the output channel (out_valid/out_ready): value and invalid. Ticks
//   answer zero.
//   Configuration channel (cfg_valid/cfg_ready) writes key_map (index 0)
//   or key_enable (index 1); it is always ready and should be written
//   only while no item is in flight.
//   A beat is held in the input register, then in the result register,
//   which drives the output. One item per cycle while the output drains,
//   set by the single pass of counter and query logic between the input
//   register and the result register.
//   Reset clears all counters, trigger and toggle flags, the configuration
//   registers and the pipeline valid bits. When the receiver stalls, the
//   result is held and one more item is accepted into the input register;
//   further beats wait until the output drains.
module button_hold_edge_toggle_tracker_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bht_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bht_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 req_type,
    input  logic [bht_pkg::PAD_W-1:0]            pad_bits,
    input  logic [bht_pkg::KEY_W-1:0]            key_bits,
    input  logic [bht_pkg::BUTTON_W-1:0]         button,
    input  logic [1:0]                           mode,
    // results
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bht_pkg::VALUE_W-1:0]          value,
    output logic                                 invalid
);

    // Configuration registers.
    logic [bht_pkg::KEY_MAP_W-1:0] key_map_reg;
    logic [bht_pkg::KEY_W-1:0]     key_enable_reg;

    // Tracker state.
    bht_pkg::count_t pad_hold_reg [bht_pkg::NUM_BUTTONS];
    bht_pkg::count_t key_hold_reg [bht_pkg::NUM_KEYS];
    logic [bht_pkg::NUM_BUTTONS-1:0] armed_reg;
    logic [bht_pkg::NUM_BUTTONS-1:0] toggle_reg;

    // Input register.
    logic                          s1_valid_reg;
    logic                          s1_req_reg;
    logic [bht_pkg::PAD_W-1:0]     s1_pad_reg;
    logic [bht_pkg::KEY_W-1:0]     s1_key_reg;
    logic [bht_pkg::BUTTON_W-1:0]  s1_button_reg;
    logic [1:0]                    s1_mode_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [bht_pkg::VALUE_W-1:0]   value_reg;
    logic                          invalid_reg;

    // Next values.
    bht_pkg::count_t pad_hold_next [bht_pkg::NUM_BUTTONS];
    bht_pkg::count_t key_hold_next [bht_pkg::NUM_KEYS];
    logic [bht_pkg::NUM_BUTTONS-1:0] armed_next;
    logic [bht_pkg::NUM_BUTTONS-1:0] toggle_next;
    logic [bht_pkg::VALUE_W-1:0]     value_next;
    logic                            invalid_next;

    logic s1_advance;
    logic s1_fire;
    logic in_fire;

    // Pipeline flow control: the input register moves on whenever the
    // result register is empty or being drained.
    assign s1_advance = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign invalid   = invalid_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_map_reg    <= '0;
            key_enable_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bht_pkg::CFG_KEY_MAP:    key_map_reg    <= cfg_data[bht_pkg::KEY_MAP_W-1:0];
                bht_pkg::CFG_KEY_ENABLE: key_enable_reg <= cfg_data[bht_pkg::KEY_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Tick path: bump every counter, then merge enabled keys by maximum.
    always_comb
    begin
        bht_pkg::key_slots_t slots;
        bht_pkg::count_t     pad_bumped;
        for (int k = 0; k < bht_pkg::NUM_KEYS; k++)
            key_hold_next[k] = bht_pkg::bump(key_hold_reg[k], s1_key_reg[k]);
        for (int b = 0; b < bht_pkg::NUM_BUTTONS; b++)
        begin
            slots = '0;
            for (int k = 0; k < bht_pkg::NUM_KEYS; k++)
            begin
                if (key_enable_reg[k] &&
                    key_map_reg[k*bht_pkg::MAP_FIELD_W +: bht_pkg::MAP_FIELD_W]
                        == bht_pkg::MAP_FIELD_W'(b))
                    slots[k] = key_hold_next[k];
            end
            pad_bumped       = bht_pkg::bump(pad_hold_reg[b], s1_pad_reg[b]);
            pad_hold_next[b] = bht_pkg::max2(pad_bumped, bht_pkg::max_tree(slots));
        end
    end

    // Query path: read one button, evaluate trigger and toggle.
    always_comb
    begin
        logic [bht_pkg::BTN_IDX_W-1:0] idx;
        bht_pkg::count_t               cnt;
        logic                          nz;
        logic                          fired;
        logic                          tog;
        logic                          in_range;
        idx      = s1_button_reg[bht_pkg::BTN_IDX_W-1:0];
        cnt      = pad_hold_reg[idx];
        nz       = (cnt != '0);
        fired    = armed_reg[idx] && !nz;
        tog      = toggle_reg[idx];
        in_range = (32'(s1_button_reg) < bht_pkg::NUM_BUTTONS);

        armed_next   = armed_reg;
        toggle_next  = toggle_reg;
        value_next   = '0;
        invalid_next = 1'b0;

        if (s1_req_reg == bht_pkg::REQ_QUERY &&
            bht_pkg::mode_t'(s1_mode_reg) != bht_pkg::MODE_NONE)
        begin
            if (!in_range)
                invalid_next = 1'b1;
            else
            begin
                case (bht_pkg::mode_t'(s1_mode_reg))
                    bht_pkg::MODE_HOLD:
                        value_next = bht_pkg::clamp_value(cnt);
                    bht_pkg::MODE_TRIGGER:
                    begin
                        // Armed goes high while held and drops on release.
                        armed_next[idx] = nz;
                        value_next      = bht_pkg::VALUE_W'(fired);
                    end
                    bht_pkg::MODE_TOGGLE:
                    begin
                        armed_next[idx]  = nz;
                        toggle_next[idx] = tog ^ fired;
                        if (tog != fired)
                            value_next = bht_pkg::clamp_value(cnt);
                    end
                    default:
                        value_next = '0;
                endcase
            end
        end
    end

    // Tracker state update, once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < bht_pkg::NUM_BUTTONS; b++)
                pad_hold_reg[b] <= '0;
            for (int k = 0; k < bht_pkg::NUM_KEYS; k++)
                key_hold_reg[k] <= '0;
            armed_reg  <= '0;
            toggle_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_req_reg == bht_pkg::REQ_TICK)
            begin
                pad_hold_reg <= pad_hold_next;
                key_hold_reg <= key_hold_next;
            end
            else
            begin
                armed_reg  <= armed_next;
                toggle_reg <= toggle_next;
            end
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg    <= req_type;
            s1_pad_reg    <= pad_bits;
            s1_key_reg    <= key_bits;
            s1_button_reg <= button;
            s1_mode_reg   <= mode;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            value_reg   <= value_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

### rtl/bht_checker.sv
// Port-level checker for the button tracker, bound to the top level.
// Depends on bht_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "button_hold_edge_toggle_tracker_core_macros.svh"

module bht_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [bht_pkg::VALUE_W-1:0]     value,
    input  logic                            invalid
);

    // A stalled result beat stays offered.
    `BHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // A stalled result beat keeps its payload.
    `BHT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(value) && $stable(invalid))

    // An out-of-range query never carries a value.
    `BHT_ASSERT_SAME(a_invalid_zero, out_valid && invalid, value == '0)

    // With the result register empty, the input side can always take a beat.
    `BHT_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind button_hold_edge_toggle_tracker_core bht_checker u_bht_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .invalid   (invalid)
);
